// ===== design/eic_pkg.sv =====
// ----------------------------------------------------------------------------
// eic_pkg
// Shared types and fixed-point constants of the ellipse inlier counter.
// ----------------------------------------------------------------------------
package eic_pkg;

  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CEN_W     = 16;
  localparam int ROT_W     = 16;
  localparam int INV_W     = 31;
  localparam int THR_W     = 24;
  localparam int E_W       = 25;
  localparam int F_W       = 31;
  localparam int OUT_CNT_W = 16;
  localparam int SQ_SPLIT  = 24;
  localparam int R2_SPLIT  = 21;
  localparam int RND_SHIFT = 14;
  localparam int F_SHIFT   = 18;
  localparam int THR_SHIFT = 16;
  localparam int STEP_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_A_SQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_B_SQ  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd6;

  localparam logic [ROT_W-1:0] ROT_COS_RST = 16'd16384;
  localparam logic [THR_W-1:0] THR_RST     = 24'd256;

  // 0.5 in Q.14 for rounding, 1.0 and the cap of 256.0 in Q.16
  localparam logic [RND_SHIFT-1:0] ROUND_HALF = 14'd8192;
  localparam logic [E_W-1:0]       ONE_Q16    = 25'd65536;
  localparam logic [E_W-1:0]       H_CAP      = 25'd16777216;

  localparam logic [STEP_W-1:0] STEP_LAST = 5'd19;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TX_COS,
    MUL_TY_SIN,
    MUL_TX_SIN,
    MUL_TY_COS,
    MUL_TX_SQ,
    MUL_TY_SQ,
    MUL_RX_SQ,
    MUL_RY_SQ,
    MUL_SQA_LO,
    MUL_SQA_HI,
    MUL_SQB_LO,
    MUL_SQB_HI,
    MUL_E_SQ,
    MUL_R2_LO,
    MUL_R2_HI
  } mul_op_e;

  typedef struct packed {
    logic    load;
    mul_op_e op;
    logic    finish;
  } eic_cmd_t;

  // multiplier schedule; gaps wait for registered intermediates
  function automatic mul_op_e step_op(input logic [STEP_W-1:0] step);
    mul_op_e op;
    case (step)
      5'd0:    op = MUL_TX_COS;
      5'd1:    op = MUL_TY_SIN;
      5'd2:    op = MUL_TX_SIN;
      5'd3:    op = MUL_TY_COS;
      5'd4:    op = MUL_TX_SQ;
      5'd5:    op = MUL_TY_SQ;
      5'd6:    op = MUL_RX_SQ;
      5'd7:    op = MUL_RY_SQ;
      5'd8:    op = MUL_SQA_LO;
      5'd9:    op = MUL_SQA_HI;
      5'd10:   op = MUL_SQB_LO;
      5'd11:   op = MUL_SQB_HI;
      5'd14:   op = MUL_E_SQ;
      5'd16:   op = MUL_R2_LO;
      5'd17:   op = MUL_R2_HI;
      default: op = MUL_NONE;
    endcase
    return op;
  endfunction

endpackage

// ===== design/eic_point_if.sv =====
// ----------------------------------------------------------------------------
// eic_point_if
// Request channel carrying one edge point and its last flag.
// ----------------------------------------------------------------------------
interface eic_point_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last;

  modport source (output valid, point_x, point_y, last, input ready);
  modport sink   (input valid, point_x, point_y, last, output ready);
endinterface

// ===== design/eic_result_if.sv =====
// ----------------------------------------------------------------------------
// eic_result_if
// Result channel carrying the per-point inlier flag and running counts.
// ----------------------------------------------------------------------------
interface eic_result_if;
  logic                           valid;
  logic                           ready;
  logic                           is_inlier;
  logic [eic_pkg::OUT_CNT_W-1:0]  inlier_count;
  logic [eic_pkg::OUT_CNT_W-1:0]  point_count;
  logic                           last_out;

  modport source (output valid, is_inlier, inlier_count, point_count, last_out,
                  input ready);
  modport sink   (input valid, is_inlier, inlier_count, point_count, last_out,
                  output ready);
endinterface

// ===== design/ellipse_inlier_counter.sv =====
// ----------------------------------------------------------------------------
// ellipse_inlier_counter
// Counts edge points lying near a configured ellipse.
// ----------------------------------------------------------------------------
// Each point is accepted in ST_IDLE and then runs 20 schedule steps
// on a single shared 32x32 multiplier (15 multiplications, with gaps where
// a step waits on a registered intermediate). A result sits in an output
// register, so the next point is accepted while it waits to be taken; a
// point finishing while the previous result is still held waits at its
// last step. Configuration writes go straight to the registers and should
// only be made while no point is in flight.
// ----------------------------------------------------------------------------
module ellipse_inlier_counter #(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  eic_point_if.sink                      in_i,
  eic_result_if.source                   out_o,
  input  logic                           cfg_we_i,
  input  logic [eic_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eic_pkg::CFG_W-1:0]      cfg_data_i
);

  eic_pkg::eic_cmd_t cmd;

  eic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  eic_dp #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .point_x_i      (in_i.point_x),
    .point_y_i      (in_i.point_y),
    .last_i         (in_i.last),
    .is_inlier_o    (out_o.is_inlier),
    .inlier_count_o (out_o.inlier_count),
    .point_count_o  (out_o.point_count),
    .last_out_o     (out_o.last_out)
  );

endmodule

// ===== design/eic_mul.sv =====
// ----------------------------------------------------------------------------
// eic_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module eic_mul (
  input  logic                       clk_i,
  input  logic [eic_pkg::MUL_W-1:0]  a_i,
  input  logic [eic_pkg::MUL_W-1:0]  b_i,
  output logic [eic_pkg::PROD_W-1:0] p_o
);

  logic [eic_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= eic_pkg::PROD_W'(a_i) * eic_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== design/eic_ctrl.sv =====
// ----------------------------------------------------------------------------
// eic_ctrl
// Sequencer: accepts a point, steps the multiplier schedule, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module eic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output eic_pkg::eic_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                       state_q, state_d;
  logic [eic_pkg::STEP_W-1:0]   step_q, step_d;
  logic                         out_valid_q, out_valid_d;
  logic                         at_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign at_last    = (state_q == ST_RUN) && (step_q == eic_pkg::STEP_LAST);

  always_comb begin
    cmd_o.load   = in_valid_i && (state_q == ST_IDLE);
    cmd_o.op     = (state_q == ST_RUN) ? eic_pkg::step_op(step_q) : eic_pkg::MUL_NONE;
    cmd_o.finish = at_last && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (cmd_o.finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else if (!at_last) begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_RUN) && (step_q == '0))
    else $error("accepted point did not start the schedule");

  a_step_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && !at_last |=> (state_q == ST_RUN) &&
    (step_q == $past(step_q) + 1'b1))
    else $error("schedule step skipped or stalled");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished point not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && at_last |=> out_valid_q && at_last)
    else $error("pending result lost while stalled");

endmodule

// ===== design/eic_dp.sv =====
// ----------------------------------------------------------------------------
// eic_dp
// Datapath: configuration registers, translate/rotate/ellipse arithmetic on
// one shared multiplier, distance compare and saturating counters.
// ----------------------------------------------------------------------------
module eic_dp #(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  eic_pkg::eic_cmd_t                 cmd_i,
  input  logic                              cfg_we_i,
  input  logic [eic_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [eic_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [COORD_BITS-1:0]             point_x_i,
  input  logic [COORD_BITS-1:0]             point_y_i,
  input  logic                              last_i,
  output logic                              is_inlier_o,
  output logic [eic_pkg::OUT_CNT_W-1:0]     inlier_count_o,
  output logic [eic_pkg::OUT_CNT_W-1:0]     point_count_o,
  output logic                              last_out_o
);

  localparam int TW  = (COORD_BITS + 4 >= eic_pkg::CEN_W) ? COORD_BITS + 5
                                                          : eic_pkg::CEN_W + 1;
  localparam int AW  = TW - 1;
  localparam int RW  = AW + 17;
  localparam int MW  = AW + 3;
  localparam int SQW = 2 * MW;
  localparam int R2W = 2 * AW + 1;
  localparam int HW  = SQW + 9;
  localparam int PW  = R2W + eic_pkg::F_W;

  // configuration
  logic [eic_pkg::CEN_W-1:0] center_x_q, center_y_q;
  logic [eic_pkg::ROT_W-1:0] rot_cos_q, rot_sin_q;
  logic [eic_pkg::INV_W-1:0] inv_a_q, inv_b_q;
  logic [eic_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      rot_cos_q  <= eic_pkg::ROT_COS_RST;
      rot_sin_q  <= '0;
      inv_a_q    <= '0;
      inv_b_q    <= '0;
      thr_q      <= eic_pkg::THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        eic_pkg::CFG_CENTER_X:  center_x_q <= cfg_data_i[eic_pkg::CEN_W-1:0];
        eic_pkg::CFG_CENTER_Y:  center_y_q <= cfg_data_i[eic_pkg::CEN_W-1:0];
        eic_pkg::CFG_ROT_COS:   rot_cos_q  <= cfg_data_i[eic_pkg::ROT_W-1:0];
        eic_pkg::CFG_ROT_SIN:   rot_sin_q  <= cfg_data_i[eic_pkg::ROT_W-1:0];
        eic_pkg::CFG_INV_A_SQ:  inv_a_q    <= cfg_data_i[eic_pkg::INV_W-1:0];
        eic_pkg::CFG_INV_B_SQ:  inv_b_q    <= cfg_data_i[eic_pkg::INV_W-1:0];
        eic_pkg::CFG_THRESHOLD: thr_q      <= cfg_data_i[eic_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // rotation as sign and magnitude
  logic                      cos_neg, sin_neg;
  logic [eic_pkg::ROT_W-1:0] cos_abs, sin_abs;

  assign cos_neg = rot_cos_q[eic_pkg::ROT_W-1];
  assign sin_neg = rot_sin_q[eic_pkg::ROT_W-1];
  assign cos_abs = cos_neg ? (~rot_cos_q + 1'b1) : rot_cos_q;
  assign sin_abs = sin_neg ? (~rot_sin_q + 1'b1) : rot_sin_q;

  // translation at load
  logic signed [TW-1:0] tx_d, ty_d;
  logic                 tx_neg_q, ty_neg_q;
  logic [AW-1:0]        atx_q, aty_q;
  logic                 last_q;

  assign tx_d = signed'(TW'({point_x_i, 4'b0000})) - signed'(TW'(center_x_q));
  assign ty_d = signed'(TW'({point_y_i, 4'b0000})) - signed'(TW'(center_y_q));

  // shared multiplier
  logic [eic_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [eic_pkg::PROD_W-1:0] prod;
  eic_pkg::mul_op_e           op_q;

  logic signed [RW-1:0] rx_acc_q, ry_acc_q, prs;
  logic [RW-1:0]        rx_mag, ry_mag;
  logic [RW:0]          rx_rnd, ry_rnd;
  logic [MW-1:0]        rxm_q, rym_q;
  logic [SQW-1:0]       sq_a_q, sq_b_q;
  logic [R2W-1:0]       r2_q;
  logic [HW-1:0]        h_q;
  logic [eic_pkg::E_W-1:0] h_cap, e_d, e_q;
  logic [eic_pkg::F_W-1:0] f_q;
  logic [PW-1:0]        d_q;

  always_comb begin
    case (cmd_i.op)
      eic_pkg::MUL_TX_COS: begin mul_a = 32'(atx_q); mul_b = 32'(cos_abs); end
      eic_pkg::MUL_TY_SIN: begin mul_a = 32'(aty_q); mul_b = 32'(sin_abs); end
      eic_pkg::MUL_TX_SIN: begin mul_a = 32'(atx_q); mul_b = 32'(sin_abs); end
      eic_pkg::MUL_TY_COS: begin mul_a = 32'(aty_q); mul_b = 32'(cos_abs); end
      eic_pkg::MUL_TX_SQ:  begin mul_a = 32'(atx_q); mul_b = 32'(atx_q); end
      eic_pkg::MUL_TY_SQ:  begin mul_a = 32'(aty_q); mul_b = 32'(aty_q); end
      eic_pkg::MUL_RX_SQ:  begin mul_a = 32'(rxm_q); mul_b = 32'(rxm_q); end
      eic_pkg::MUL_RY_SQ:  begin mul_a = 32'(rym_q); mul_b = 32'(rym_q); end
      eic_pkg::MUL_SQA_LO: begin
        mul_a = 32'(sq_a_q[eic_pkg::SQ_SPLIT-1:0]);
        mul_b = 32'(inv_a_q);
      end
      eic_pkg::MUL_SQA_HI: begin
        mul_a = 32'(sq_a_q[SQW-1:eic_pkg::SQ_SPLIT]);
        mul_b = 32'(inv_a_q);
      end
      eic_pkg::MUL_SQB_LO: begin
        mul_a = 32'(sq_b_q[eic_pkg::SQ_SPLIT-1:0]);
        mul_b = 32'(inv_b_q);
      end
      eic_pkg::MUL_SQB_HI: begin
        mul_a = 32'(sq_b_q[SQW-1:eic_pkg::SQ_SPLIT]);
        mul_b = 32'(inv_b_q);
      end
      eic_pkg::MUL_E_SQ:   begin mul_a = 32'(e_q); mul_b = 32'(e_q); end
      eic_pkg::MUL_R2_LO:  begin
        mul_a = 32'(r2_q[eic_pkg::R2_SPLIT-1:0]);
        mul_b = 32'(f_q);
      end
      eic_pkg::MUL_R2_HI:  begin
        mul_a = 32'(r2_q[R2W-1:eic_pkg::R2_SPLIT]);
        mul_b = 32'(f_q);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  eic_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prs = RW'(prod);

  // rounded magnitudes of the rotated coordinates, Q.4
  assign rx_mag = rx_acc_q[RW-1] ? RW'(-rx_acc_q) : RW'(rx_acc_q);
  assign ry_mag = ry_acc_q[RW-1] ? RW'(-ry_acc_q) : RW'(ry_acc_q);
  assign rx_rnd = {1'b0, rx_mag} + (RW+1)'(eic_pkg::ROUND_HALF);
  assign ry_rnd = {1'b0, ry_mag} + (RW+1)'(eic_pkg::ROUND_HALF);

  // |min(h, 256) - 1|
  assign h_cap = (h_q > HW'(eic_pkg::H_CAP)) ? eic_pkg::H_CAP : eic_pkg::E_W'(h_q);
  assign e_d   = (h_cap >= eic_pkg::ONE_Q16) ? (h_cap - eic_pkg::ONE_Q16)
                                             : (eic_pkg::ONE_Q16 - h_cap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= eic_pkg::MUL_NONE;
    end else begin
      op_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    rxm_q <= MW'(rx_rnd >> eic_pkg::RND_SHIFT);
    rym_q <= MW'(ry_rnd >> eic_pkg::RND_SHIFT);
    e_q   <= e_d;
    if (cmd_i.load) begin
      tx_neg_q <= tx_d[TW-1];
      ty_neg_q <= ty_d[TW-1];
      atx_q    <= tx_d[TW-1] ? AW'(-tx_d) : AW'(tx_d);
      aty_q    <= ty_d[TW-1] ? AW'(-ty_d) : AW'(ty_d);
      last_q   <= last_i;
    end
    case (op_q)
      eic_pkg::MUL_TX_COS: rx_acc_q <= (tx_neg_q ^ cos_neg) ? -prs : prs;
      eic_pkg::MUL_TY_SIN: rx_acc_q <= rx_acc_q + ((ty_neg_q ^ sin_neg) ? prs : -prs);
      eic_pkg::MUL_TX_SIN: ry_acc_q <= (tx_neg_q ^ sin_neg) ? -prs : prs;
      eic_pkg::MUL_TY_COS: ry_acc_q <= ry_acc_q + ((ty_neg_q ^ cos_neg) ? -prs : prs);
      eic_pkg::MUL_TX_SQ:  r2_q     <= R2W'(prod);
      eic_pkg::MUL_TY_SQ:  r2_q     <= r2_q + R2W'(prod);
      eic_pkg::MUL_RX_SQ:  sq_a_q   <= SQW'(prod);
      eic_pkg::MUL_RY_SQ:  sq_b_q   <= SQW'(prod);
      eic_pkg::MUL_SQA_LO: h_q      <= HW'(prod >> eic_pkg::SQ_SPLIT);
      eic_pkg::MUL_SQA_HI: h_q      <= h_q + HW'(prod);
      eic_pkg::MUL_SQB_LO: h_q      <= h_q + HW'(prod >> eic_pkg::SQ_SPLIT);
      eic_pkg::MUL_SQB_HI: h_q      <= h_q + HW'(prod);
      eic_pkg::MUL_E_SQ:   f_q      <= eic_pkg::F_W'(prod >> eic_pkg::F_SHIFT);
      eic_pkg::MUL_R2_LO:  d_q      <= PW'(prod);
      eic_pkg::MUL_R2_HI:  d_q      <= d_q + (PW'(prod) << eic_pkg::R2_SPLIT);
      default: ;
    endcase
  end

  // compare and count
  logic                  inlier;
  logic [COUNT_BITS-1:0] inl_q, pts_q, inl_d, pts_d;
  logic                  is_inlier_q, last_out_q;
  logic [eic_pkg::OUT_CNT_W-1:0] inl_out_q, pts_out_q;

  assign inlier = d_q < PW'({thr_q, {eic_pkg::THR_SHIFT{1'b0}}});
  assign inl_d  = (inlier && (inl_q != '1)) ? inl_q + 1'b1 : inl_q;
  assign pts_d  = (pts_q != '1) ? pts_q + 1'b1 : pts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inl_q <= '0;
      pts_q <= '0;
    end else if (cmd_i.finish) begin
      inl_q <= last_q ? '0 : inl_d;
      pts_q <= last_q ? '0 : pts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      is_inlier_q <= inlier;
      inl_out_q   <= eic_pkg::OUT_CNT_W'(inl_d);
      pts_out_q   <= eic_pkg::OUT_CNT_W'(pts_d);
      last_out_q  <= last_q;
    end
  end

  assign is_inlier_o    = is_inlier_q;
  assign inlier_count_o = inl_out_q;
  assign point_count_o  = pts_out_q;
  assign last_out_o     = last_out_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Point stream check of the ellipse inlier counter. Points go in over the
// request channel under random bursts and gaps, and results come back under
// a stall pattern. Every accepted point is run through an independent
// fixed-point predictor. Each result is compared, field by field, with the
// oldest prediction still waiting. The run covers several register settings
// and finishes with a full-rate stream of points that all count as inliers.
// ----------------------------------------------------------------------------
module tb_top;
  import eic_pkg::*;

  localparam int COORD_BITS  = 12;
  localparam int COUNT_BITS  = 16;
  localparam int COUNT_SAT   = (1 << COUNT_BITS) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam real PI         = 3.14159265358979;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic                 inlier;
    logic [OUT_CNT_W-1:0] inliers;
    logic [OUT_CNT_W-1:0] points;
    logic                 last_flag;
  } tally_t;

  class inlier_scoreboard;
    logic [CEN_W-1:0] cen_x, cen_y;
    logic [ROT_W-1:0] cos_q, sin_q;
    logic [INV_W-1:0] inv_a, inv_b;
    logic [THR_W-1:0] thr;
    int               inliers_run, points_run;
    tally_t           tally_q[$];
    int               fails;

    function new();
      cen_x       = '0;
      cen_y       = '0;
      cos_q       = ROT_COS_RST;
      sin_q       = '0;
      inv_a       = '0;
      inv_b       = '0;
      thr         = THR_RST;
      inliers_run = 0;
      points_run  = 0;
      fails       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_CENTER_X:  cen_x = data[CEN_W-1:0];
        CFG_CENTER_Y:  cen_y = data[CEN_W-1:0];
        CFG_ROT_COS:   cos_q = data[ROT_W-1:0];
        CFG_ROT_SIN:   sin_q = data[ROT_W-1:0];
        CFG_INV_A_SQ:  inv_a = data[INV_W-1:0];
        CFG_INV_B_SQ:  inv_b = data[INV_W-1:0];
        CFG_THRESHOLD: thr   = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // magnitude of a Q.18 value rounded to Q.4
    function longint unsigned round_q4(longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      return (m + 64'd8192) >> 14;
    endfunction

    // Q.8 square times Q0.32 inverse, truncated to Q.16
    function longint unsigned axis_term(longint unsigned sq, logic [INV_W-1:0] inv);
      logic [127:0] wa, wb, p;
      wa = 128'(sq);
      wb = 128'(inv);
      p  = wa * wb;
      return p[87:24];
    endfunction

    function logic near_ellipse(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      longint          tx, ty, rc, rs, rx18, ry18;
      longint unsigned h, e, f, r2;
      logic [127:0]    wr, wf, d2, bound;
      tx    = longint'(px);
      ty    = longint'(py);
      tx    = tx * 16 - longint'(cen_x);
      ty    = ty * 16 - longint'(cen_y);
      rc    = longint'(signed'(cos_q));
      rs    = longint'(signed'(sin_q));
      rx18  = tx * rc - ty * rs;
      ry18  = tx * rs + ty * rc;
      h     = axis_term(round_q4(rx18) * round_q4(rx18), inv_a) +
              axis_term(round_q4(ry18) * round_q4(ry18), inv_b);
      if (h > H_CAP) h = 64'(H_CAP);
      e     = (h >= ONE_Q16) ? h - ONE_Q16 : ONE_Q16 - h;
      f     = (e * e) >> 18;
      r2    = tx * tx + ty * ty;
      wr    = 128'(r2);
      wf    = 128'(f);
      d2    = wr * wf;
      bound = 128'(thr);
      bound = bound << 16;
      return d2 < bound;
    endfunction

    function void note_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                             logic lst);
      tally_t t;
      t.inlier = near_ellipse(px, py);
      if (t.inlier && inliers_run < COUNT_SAT) inliers_run++;
      if (points_run < COUNT_SAT) points_run++;
      t.inliers   = inliers_run[OUT_CNT_W-1:0];
      t.points    = points_run[OUT_CNT_W-1:0];
      t.last_flag = lst;
      tally_q.push_back(t);
      if (lst) begin
        inliers_run = 0;
        points_run  = 0;
      end
    endfunction

    task report(string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      fails++;
    endtask

    task check_result(logic inl, logic [OUT_CNT_W-1:0] ic, logic [OUT_CNT_W-1:0] pc,
                      logic lo);
      tally_t t;
      if (tally_q.size() == 0) begin
        report("result with no point outstanding");
      end else begin
        t = tally_q.pop_front();
        if (inl !== t.inlier)
          report($sformatf("is_inlier got %0b want %0b", inl, t.inlier));
        if (ic !== t.inliers)
          report($sformatf("inlier_count got %0d want %0d", ic, t.inliers));
        if (pc !== t.points)
          report($sformatf("point_count got %0d want %0d", pc, t.points));
        if (lo !== t.last_flag)
          report($sformatf("last_out got %0b want %0b", lo, t.last_flag));
      end
    endtask

    function int pending();
      return tally_q.size();
    endfunction

    task close();
      if (tally_q.size() != 0)
        report($sformatf("%0d results never arrived", tally_q.size()));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  eic_point_if #(.COORD_BITS(COORD_BITS)) pt_if ();
  eic_result_if                           res_if ();

  inlier_scoreboard sb = new();

  bit sender_idle_on = 1'b1;
  bit full_rate      = 1'b0;
  bit hold_armed     = 1'b0;
  int burst_left     = 0;

  ellipse_inlier_counter #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pt_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    if (!sender_idle_on) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return $urandom_range(1, 25);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(real v);
    int k;
    k = $rtoi(v);
    if (k < 0) k = 0;
    if (k > 4095) k = 4095;
    return k[COORD_BITS-1:0];
  endfunction

  task automatic send_point(input logic [COORD_BITS-1:0] px,
                            input logic [COORD_BITS-1:0] py, input logic lst);
    int gap;
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    pt_if.last    <= lst;
    do @(posedge clk_i); while (!pt_if.ready);
    sb.note_point(px, py, lst);
    gap = pick_gap();
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                              input logic [CFG_W-1:0] cs, input logic [CFG_W-1:0] sn,
                              input logic [CFG_W-1:0] ia, input logic [CFG_W-1:0] ib,
                              input logic [CFG_W-1:0] th);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_ROT_COS, cs);
    write_reg(CFG_ROT_SIN, sn);
    write_reg(CFG_INV_A_SQ, ia);
    write_reg(CFG_INV_B_SQ, ib);
    write_reg(CFG_THRESHOLD, th);
    // unmapped index, must leave every register alone
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    pt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int n_points, input bit shaped, input bit pressure);
    real                   theta, ax, bx, phi, ux, uy;
    int                    cxp, cyp, jx, jy;
    logic [COORD_BITS-1:0] px, py;
    theta = 0.0;
    ax    = 1.0;
    bx    = 1.0;
    cxp   = 0;
    cyp   = 0;
    if (shaped) begin
      cxp   = $urandom_range(0, 4095);
      cyp   = $urandom_range(0, 4095);
      theta = $urandom_range(0, 3599) * PI / 1800.0;
      ax    = $urandom_range(3, 600);
      bx    = $urandom_range(3, 600);
      program_regs(CFG_W'(cxp * 16 + $urandom_range(0, 15)),
                   CFG_W'(cyp * 16 + $urandom_range(0, 15)),
                   CFG_W'($rtoi($cos(theta) * 16384.0)),
                   CFG_W'(-$rtoi($sin(theta) * 16384.0)),
                   CFG_W'($rtoi(4294967296.0 / (ax * ax))),
                   CFG_W'($rtoi(4294967296.0 / (bx * bx))),
                   CFG_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                      : $urandom_range(0, 2048)));
    end else begin
      program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    end
    if (pressure) hold_armed = 1'b1;
    for (int i = 0; i < n_points; i++) begin
      if (shaped && $urandom_range(0, 3) != 0) begin
        phi = $urandom_range(0, 3599) * PI / 1800.0;
        jx  = $urandom_range(0, 40);
        jy  = $urandom_range(0, 40);
        ux  = ax * $cos(phi) + (jx - 20) / 10.0;
        uy  = bx * $sin(phi) + (jy - 20) / 10.0;
        px  = clamp_coord(cxp + ux * $cos(theta) - uy * $sin(theta));
        py  = clamp_coord(cyp + ux * $sin(theta) + uy * $cos(theta));
      end else begin
        px = COORD_BITS'($urandom_range(0, 4095));
        py = COORD_BITS'($urandom_range(0, 4095));
      end
      send_point(px, py, $urandom_range(0, 15) == 0);
    end
    settle();
  endtask

  // result side: stall pattern, one long hold-off on request
  initial begin : result_sink
    int          hold_left, style_left, style;
    logic [15:0] pat;
    hold_left    = 0;
    style_left   = 0;
    style        = 0;
    pat          = '1;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready)
        sb.check_result(res_if.is_inlier, res_if.inlier_count, res_if.point_count,
                        res_if.last_out);
      if (hold_armed) begin
        hold_left  = HOLD_CYCLES;
        hold_armed = 1'b0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(20, 300);
        pat        = 16'((style == 1) ? $urandom : ($urandom | $urandom));
      end
      style_left--;
      pat = {pat[14:0], pat[15]};
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (full_rate || style == 0) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= pat[0];
      end
    end
  end

  initial begin : point_source
    rst_ni        = 1'b0;
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.last    = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: unit circle terms are zero, inlier only within ~2 px
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b0);
    send_point(2, 0, 1'b0);
    send_point(4095, 4095, 1'b1);
    settle();

    // 30 degree ellipse, a = 40, b = 20, centre (100, 80)
    program_regs(1600, 1280, 14189, CFG_W'(-8192), 2684355, 10737418, 512);
    send_point(100, 80, 1'b0);
    send_point(135, 100, 1'b0);
    send_point(90, 97, 1'b0);
    send_point(65, 60, 1'b0);
    send_point(4095, 0, 1'b0);
    send_point(0, 4095, 1'b1);
    settle();

    // out of range rotation and inverses, h saturates
    program_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_8000, 31'h0000_7FFF, 31'h7FFF_FFFF,
                 31'h7FFF_FFFF, 31'h00FF_FFFF);
    send_point(0, 0, 1'b0);
    send_point(4095, 4095, 1'b0);
    send_point(4095, 0, 1'b0);
    send_point(2048, 2048, 1'b1);
    settle();

    // zero threshold
    program_regs(32768, 32768, CFG_W'(ROT_COS_RST), 0, 1000, 1000, 0);
    send_point(2048, 2048, 1'b0);
    send_point(2047, 2048, 1'b1);
    settle();

    // a = b = 2 px at 90 degrees; a point exactly on the curve gives h = 1
    program_regs(16000, 16000, 0, 16384, 31'h4000_0000, 31'h4000_0000, CFG_W'(THR_RST));
    send_point(1002, 1000, 1'b0);
    send_point(1000, 1003, 1'b0);
    send_point(1000, 1000, 1'b1);
    settle();

    for (int k = 0; k < 10; k++) begin
      sender_idle_on = (k != 2) && (k != 6);
      run_random_phase(125, (k % 4) != 3, k == 2);
    end

    // full rate, every point an inlier
    full_rate      = 1'b1;
    sender_idle_on = 1'b0;
    program_regs(0, 0, CFG_W'(ROT_COS_RST), 0, 0, 0, 31'h00FF_FFFF);
    for (int n = 0; n < 20; n++)
      send_point(COORD_BITS'($urandom_range(0, 31)), COORD_BITS'($urandom_range(0, 31)),
                 1'b0);
    send_point(5, 5, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(1, 1, 1'b1);
    settle();

    repeat (40) @(posedge clk_i);
    sb.close();
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(40_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
